// ----- hw/rtl/sorted_timeout_queue_defines.svh -----
// Assertion macros used by the sorted timeout queue top level.
`ifndef SORTED_TIMEOUT_QUEUE_DEFINES_SVH
`define SORTED_TIMEOUT_QUEUE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define STQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define STQ_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/stq_pkg.sv -----
// Types, constants and helper functions of the sorted timeout queue.
package stq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_SLOTS        = 16;

	localparam int OP_W      = 2;
	localparam int IVAL_W    = 31;
	localparam int SEC_W     = 32;
	localparam int USEC_W    = 20;
	localparam int OWNER_W   = 16;
	localparam int ID_W      = 4;
	localparam int STATUS_W  = 2;
	localparam int ENTRY_W   = SEC_W + USEC_W + OWNER_W;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 32;

	localparam int USEC_PER_SEC = 1000000;
	localparam int MS_PER_SEC   = 1000;

	// floor(ms / 1000) == (ms * MS_RECIP) >> MS_RECIP_SHIFT for every 31-bit ms
	localparam logic [31:0] MS_RECIP = 32'd2199023256;
	localparam int MS_RECIP_SHIFT = 41;
	localparam int SEC_QUOT_W     = 22;
	localparam int MS_REM_W       = 10;
	localparam int USEC_SUM_W     = 21;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_POLL   = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_WALK,
		S_REMOVE,
		S_POLL,
		S_DONE
	} state_t;

	typedef struct packed {
		logic ins;
		logic del;
	} ord_ctl_t;

	// true when time a is strictly later than time b
	function automatic logic later(input logic [SEC_W-1:0] a_sec, input logic [USEC_W-1:0] a_usec,
			input logic [SEC_W-1:0] b_sec, input logic [USEC_W-1:0] b_usec);
		return (a_sec > b_sec) || ((a_sec == b_sec) && (a_usec > b_usec));
	endfunction

endpackage

// ----- hw/rtl/stq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module stq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/stq_deadline.sv -----
// Deadline unit: now plus a millisecond interval, normalized and saturated.
module stq_deadline (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [stq_pkg::IVAL_W-1:0]  interval_ms,
	input  logic [stq_pkg::SEC_W-1:0]   now_sec,
	input  logic [stq_pkg::USEC_W-1:0]  now_usec,
	output logic                        done,
	output logic [stq_pkg::SEC_W-1:0]   dl_sec,
	output logic [stq_pkg::USEC_W-1:0]  dl_usec
);

	localparam int QW = stq_pkg::SEC_QUOT_W;
	localparam int RW = stq_pkg::MS_REM_W;
	localparam int UW = stq_pkg::USEC_SUM_W;
	localparam int PROD_W = stq_pkg::IVAL_W + 32;

	logic [4:0]                  step_q;
	logic [stq_pkg::IVAL_W-1:0]  ival_q;
	logic [stq_pkg::SEC_W-1:0]   ns_q;
	logic [stq_pkg::USEC_W-1:0]  nu_q;
	logic [QW-1:0]               quot_q;
	logic [RW-1:0]               rem_q;
	logic                        carry_q;
	logic [stq_pkg::USEC_W-1:0]  usec_q;
	logic [stq_pkg::SEC_W-1:0]   sec_q;

	logic [PROD_W-1:0]           prod;
	logic [31:0]                 quot_ms;
	logic [UW-1:0]               us_sum;
	logic [stq_pkg::SEC_W:0]     sec_sum;

	always_comb begin
		prod    = PROD_W'(ival_q) * PROD_W'(stq_pkg::MS_RECIP);
		quot_ms = 32'(quot_q) * 32'(stq_pkg::MS_PER_SEC);
		us_sum  = UW'(rem_q) * UW'(stq_pkg::MS_PER_SEC) + UW'(nu_q);
		sec_sum = (stq_pkg::SEC_W+1)'(quot_q) + (stq_pkg::SEC_W+1)'(ns_q)
			+ (stq_pkg::SEC_W+1)'(carry_q);
	end

	// one step per cycle: quotient, remainder, microseconds, seconds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= {step_q[3:0], start};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ival_q <= interval_ms;
			ns_q   <= now_sec;
			nu_q   <= now_usec;
		end
		if (step_q[0]) begin
			quot_q <= prod[stq_pkg::MS_RECIP_SHIFT +: QW];
		end
		if (step_q[1]) begin
			rem_q <= RW'(ival_q - stq_pkg::IVAL_W'(quot_ms));
		end
		if (step_q[2]) begin
			if (us_sum >= UW'(stq_pkg::USEC_PER_SEC)) begin
				usec_q  <= stq_pkg::USEC_W'(us_sum - UW'(stq_pkg::USEC_PER_SEC));
				carry_q <= 1'b1;
			end else begin
				usec_q  <= stq_pkg::USEC_W'(us_sum);
				carry_q <= 1'b0;
			end
		end
		if (step_q[3]) begin
			sec_q <= sec_sum[stq_pkg::SEC_W] ? '1 : sec_sum[stq_pkg::SEC_W-1:0];
		end
	end

	assign done    = step_q[4];
	assign dl_sec  = sec_q;
	assign dl_usec = usec_q;

endmodule

// ----- hw/rtl/stq_order.sv -----
// Queue order list: slot id at each queue position, with insert and delete shifts.
module stq_order #(
	parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF,
	localparam int CAP = (QUEUE_DEPTH < stq_pkg::ID_SLOTS) ? QUEUE_DEPTH : stq_pkg::ID_SLOTS,
	localparam int SW  = $clog2(CAP),
	localparam int PW  = $clog2(CAP + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stq_pkg::ord_ctl_t ctl,
	input  logic [PW-1:0]     pos,
	input  logic [SW-1:0]     slot,
	input  logic [PW-1:0]     rd_pos,
	output logic [SW-1:0]     rd_slot,
	output logic [PW-1:0]     count
);

	logic [SW-1:0] ord_q [CAP];
	logic [SW-1:0] ord_d [CAP];
	logic [PW-1:0] count_q;

	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			ord_d[i] = ord_q[i];
			if (ctl.ins) begin
				if (PW'(i) > pos) begin
					ord_d[i] = ord_q[(i == 0) ? 0 : i - 1];
				end else if (PW'(i) == pos) begin
					ord_d[i] = slot;
				end
			end else if (ctl.del) begin
				if (PW'(i) >= pos) begin
					ord_d[i] = ord_q[(i == CAP - 1) ? i : i + 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAP; i++) begin
			ord_q[i] <= ord_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + PW'(1);
		end else if (ctl.del) begin
			count_q <= count_q - PW'(1);
		end
	end

	assign rd_slot = (rd_pos < PW'(CAP)) ? ord_q[rd_pos[SW-1:0]] : ord_q[0];
	assign count   = count_q;

endmodule

// ----- hw/rtl/sorted_timeout_queue.sv -----
// Top level of the sorted timeout queue: sequencer, slot allocation and result register.
//
//  channel | dir | beat                                   | accepted when
//  --------+-----+----------------------------------------+------------------------
//  s_*     | in  | one request: add, remove, poll or nop   | s_tvalid && s_tready
//  m_*     | out | one result per request                  | m_tvalid && m_tready
//
// Steps: an add runs the deadline unit, then walks the entry RAM one entry per cycle
// with the shared time comparator to find the queue position it lands at. A remove
// walks the order list for the id. A poll compares the head entry with the current
// time. A full add, an absent id, a nop or a poll on an empty queue go straight to
// the result.
// s_tready is high only between requests; a finished result parks in the m_* register,
// so the next request is taken while that result waits. A stalled m_* holds the
// sequencer in its last state. Reset clears queue count, slot flags and handshakes at
// once; the entry RAM and order list hold no reset and are read only where written.
module sorted_timeout_queue #(
	parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF,
	localparam int CAP = (QUEUE_DEPTH < stq_pkg::ID_SLOTS) ? QUEUE_DEPTH : stq_pkg::ID_SLOTS,
	localparam int SW  = $clog2(CAP),
	localparam int PW  = $clog2(CAP + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [1:0] opcode, [32:2] interval_ms, [64:33] now_sec, [84:65] now_usec,
	// [100:85] owner_tag, [104:101] cancel_id, [111:105] zero
	input  logic [stq_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [1:0] status, [5:2] assigned_id, [6] expired, [10:7] expired_id,
	// [26:11] expired_owner, [31:27] zero
	output logic [stq_pkg::OUT_DATA_W-1:0] m_tdata
);

	`include "sorted_timeout_queue_defines.svh"

	localparam int IDW = stq_pkg::ID_W;
	localparam int SECW = stq_pkg::SEC_W;
	localparam int USW = stq_pkg::USEC_W;
	localparam int OWW = stq_pkg::OWNER_W;

	// unpacked request fields
	stq_pkg::opcode_t           in_op;
	logic [stq_pkg::IVAL_W-1:0] in_ival;
	logic [SECW-1:0]            in_sec;
	logic [USW-1:0]             in_usec;
	logic [OWW-1:0]             in_owner;
	logic [IDW-1:0]             in_cid;

	assign in_op    = stq_pkg::opcode_t'(s_tdata[1:0]);
	assign in_ival  = s_tdata[32:2];
	assign in_sec   = s_tdata[64:33];
	assign in_usec  = s_tdata[84:65];
	assign in_owner = s_tdata[100:85];
	assign in_cid   = s_tdata[104:101];

	stq_pkg::state_t state_q, state_d;

	logic              accept;
	logic              out_free;
	logic              out_load;

	// held request
	logic [SECW-1:0]   now_sec_q;
	logic [USW-1:0]    now_usec_q;
	logic [OWW-1:0]    owner_q;
	logic [SW-1:0]     cid_q;
	logic [PW-1:0]     p_q;
	logic [CAP-1:0]    busy_q;

	// result in progress and result register
	stq_pkg::status_t  res_status_q;
	logic [IDW-1:0]    res_aid_q;
	logic              res_exp_q;
	logic [IDW-1:0]    res_eid_q;
	logic [OWW-1:0]    res_eown_q;
	logic              m_tvalid_q;
	logic [stq_pkg::OUT_DATA_W-1:0] m_data_q;

	// deadline unit
	logic              dl_done;
	logic [SECW-1:0]   dl_sec;
	logic [USW-1:0]    dl_usec;

	// order list
	stq_pkg::ord_ctl_t ord_ctl;
	logic [PW-1:0]     ord_pos;
	logic [PW-1:0]     rd_pos;
	logic [SW-1:0]     rd_slot;
	logic [PW-1:0]     count;

	// entry RAM, indexed by slot id
	logic                         ram_we;
	logic [stq_pkg::ENTRY_W-1:0]  ram_rdata;
	logic [SECW-1:0]              rd_sec;
	logic [USW-1:0]               rd_usec;
	logic [OWW-1:0]               rd_owner;

	// decisions
	logic              full;
	logic              in_cid_busy;
	logic [SW-1:0]     free_slot;
	logic [SECW-1:0]   cmp_sec;
	logic [USW-1:0]    cmp_usec;
	logic              cmp_later;
	logic              walk_more;
	logic              hit;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign rd_sec   = ram_rdata[stq_pkg::ENTRY_W-1 -: SECW];
	assign rd_usec  = ram_rdata[OWW +: USW];
	assign rd_owner = ram_rdata[OWW-1:0];

	assign full = (count >= PW'(CAP));
	assign in_cid_busy = ({1'b0, in_cid} < (IDW+1)'(CAP)) && busy_q[in_cid[SW-1:0]];

	// lowest free slot id
	always_comb begin
		free_slot = '0;
		for (int i = CAP - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_slot = SW'(i);
			end
		end
	end

	// shared time comparator: new deadline during the walk, current time on poll
	always_comb begin
		cmp_sec  = (state_q == stq_pkg::S_POLL) ? now_sec_q : dl_sec;
		cmp_usec = (state_q == stq_pkg::S_POLL) ? now_usec_q : dl_usec;
		cmp_later = stq_pkg::later(cmp_sec, cmp_usec, rd_sec, rd_usec);
	end

	assign walk_more = (p_q < count) && cmp_later;
	assign hit       = (rd_slot == cid_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			stq_pkg::S_IDLE: begin
				if (accept) begin
					case (in_op)
						stq_pkg::OP_ADD:    state_d = full ? stq_pkg::S_DONE : stq_pkg::S_CALC;
						stq_pkg::OP_REMOVE: state_d = in_cid_busy ? stq_pkg::S_REMOVE
							: stq_pkg::S_DONE;
						stq_pkg::OP_POLL:   state_d = (count != '0) ? stq_pkg::S_POLL
							: stq_pkg::S_DONE;
						default:            state_d = stq_pkg::S_DONE;
					endcase
				end
			end
			stq_pkg::S_CALC: begin
				if (dl_done) begin
					state_d = stq_pkg::S_WALK;
				end
			end
			stq_pkg::S_WALK: begin
				if (!walk_more) begin
					state_d = stq_pkg::S_DONE;
				end
			end
			stq_pkg::S_REMOVE: begin
				if (hit) begin
					state_d = stq_pkg::S_DONE;
				end
			end
			stq_pkg::S_POLL: state_d = stq_pkg::S_DONE;
			stq_pkg::S_DONE: begin
				if (out_free) begin
					state_d = stq_pkg::S_IDLE;
				end
			end
			default: state_d = stq_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		ord_ctl  = '0;
		ord_pos  = '0;
		rd_pos   = '0;
		ram_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			stq_pkg::S_IDLE: s_tready = 1'b1;
			stq_pkg::S_WALK: begin
				// fetch the next position while comparing this one
				rd_pos = p_q + PW'(1);
				if (!walk_more) begin
					ord_ctl.ins = 1'b1;
					ord_pos     = p_q;
					ram_we      = 1'b1;
				end
			end
			stq_pkg::S_REMOVE: begin
				rd_pos = p_q;
				if (hit) begin
					ord_ctl.del = 1'b1;
					ord_pos     = p_q;
				end
			end
			stq_pkg::S_POLL: begin
				if (cmp_later) begin
					ord_ctl.del = 1'b1;
				end
			end
			stq_pkg::S_DONE: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// walk position and slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q    <= '0;
			busy_q <= '0;
		end else begin
			case (state_q)
				stq_pkg::S_IDLE: p_q <= '0;
				stq_pkg::S_WALK: begin
					if (walk_more) begin
						p_q <= p_q + PW'(1);
					end else begin
						busy_q[free_slot] <= 1'b1;
					end
				end
				stq_pkg::S_REMOVE: begin
					if (hit) begin
						busy_q[cid_q] <= 1'b0;
					end else begin
						p_q <= p_q + PW'(1);
					end
				end
				stq_pkg::S_POLL: begin
					if (cmp_later) begin
						busy_q[rd_slot] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// request hold and result build-up
	always_ff @(posedge clk) begin
		if (accept) begin
			now_sec_q    <= in_sec;
			now_usec_q   <= in_usec;
			owner_q      <= in_owner;
			cid_q        <= in_cid[SW-1:0];
			res_aid_q    <= '0;
			res_exp_q    <= 1'b0;
			res_eid_q    <= '0;
			res_eown_q   <= '0;
			res_status_q <= stq_pkg::ST_DONE;
			if (in_op == stq_pkg::OP_ADD && full) begin
				res_status_q <= stq_pkg::ST_FULL;
			end
			if (in_op == stq_pkg::OP_REMOVE && !in_cid_busy) begin
				res_status_q <= stq_pkg::ST_NOT_FOUND;
			end
		end
		if (state_q == stq_pkg::S_WALK && !walk_more) begin
			res_aid_q <= IDW'(free_slot);
		end
		if (state_q == stq_pkg::S_POLL && cmp_later) begin
			res_exp_q  <= 1'b1;
			res_eid_q  <= IDW'(rd_slot);
			res_eown_q <= rd_owner;
		end
		if (out_load) begin
			m_data_q <= {5'd0, res_eown_q, res_eid_q, res_exp_q, res_aid_q, res_status_q};
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

	stq_deadline u_deadline (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept && in_op == stq_pkg::OP_ADD),
		.interval_ms (in_ival),
		.now_sec     (in_sec),
		.now_usec    (in_usec),
		.done        (dl_done),
		.dl_sec      (dl_sec),
		.dl_usec     (dl_usec)
	);

	stq_order #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_order (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ord_ctl),
		.pos     (ord_pos),
		.slot    (free_slot),
		.rd_pos  (rd_pos),
		.rd_slot (rd_slot),
		.count   (count)
	);

	stq_ram #(
		.WIDTH (stq_pkg::ENTRY_W),
		.DEPTH (CAP)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_slot),
		.wdata ({dl_sec, dl_usec, owner_q}),
		.raddr (rd_slot),
		.rdata (ram_rdata)
	);

	`STQ_ASSERT_ALWAYS(a_busy_matches_count, $countones(busy_q) == 32'(count), "slot flags disagree with queue count")
	`STQ_ASSERT_ALWAYS(a_count_in_range, count <= PW'(CAP), "queue count above capacity")
	`STQ_ASSERT_IMPLY(a_write_free_slot, ram_we, !busy_q[free_slot] && !full, "insert into a used slot or a full queue")
	`STQ_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "ready again right after a request")

endmodule
